@@ rtl/fptw_pkg.sv @@
package fptw_pkg;

   localparam int unsigned STORE_PAGES       = 64;
   localparam int unsigned ENTRIES_PER_TABLE = 512;
   localparam int unsigned STORE_DEPTH       = STORE_PAGES * ENTRIES_PER_TABLE;
   localparam int unsigned STORE_ADDR_W      = $clog2(STORE_DEPTH);
   localparam int unsigned ENTRY_W           = 64;
   localparam int unsigned FRAME_W           = 40;

   typedef logic [STORE_ADDR_W-1:0] store_addr_type;
   typedef logic [ENTRY_W-1:0]      entry_type;
   typedef logic [FRAME_W-1:0]      frame_type;

   typedef enum logic [2:0] {
      ST_MAP_4K      = 3'd0,
      ST_MAP_2M      = 3'd1,
      ST_MAP_1G      = 3'd2,
      ST_NOT_PRESENT = 3'd3,
      ST_OUTSIDE     = 3'd4,
      ST_WRITE_DONE  = 3'd5
   } status_type;

   typedef enum logic {
      CMD_TRANSLATE = 1'b0,
      CMD_WRITE     = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_ROOT_FRAME = 1'b0,
      CSR_STORE_BASE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      WS_IDLE,
      WS_CHECK,
      WS_EVAL,
      WS_DONE
   } walk_state_type;

   typedef struct packed {
      logic [51:0] phys_addr;
      status_type  status;
      logic [1:0]  fault_level;
   } result_type;

   typedef struct packed {
      logic           we;
      store_addr_type waddr;
      entry_type      wdata;
      logic           re;
      store_addr_type raddr;
   } ram_cmd_type;

endpackage

@@ rtl/fptw_req_if.sv @@
interface fptw_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [47:0] virt_addr;
   logic [14:0] entry_slot;
   logic [63:0] entry_value;

   modport source (output valid, output cmd, output virt_addr, output entry_slot,
                   output entry_value, input ready);
   modport sink   (input valid, input cmd, input virt_addr, input entry_slot,
                   input entry_value, output ready);
endinterface

@@ rtl/fptw_rsp_if.sv @@
interface fptw_rsp_if;
   logic        valid;
   logic        ready;
   logic [51:0] phys_addr;
   logic [2:0]  status;
   logic [1:0]  fault_level;

   modport source (output valid, output phys_addr, output status, output fault_level,
                   input ready);
   modport sink   (input valid, input phys_addr, input status, input fault_level,
                   output ready);
endinterface

@@ rtl/fptw_ram.sv @@
module fptw_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fptw_ctrl.sv @@
module fptw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   fptw_req_if.sink               req,
   input  fptw_pkg::frame_type    root_frame,
   input  fptw_pkg::frame_type    store_base_frame,
   input  logic                   out_free,
   output logic                   res_valid,
   output fptw_pkg::result_type   res,
   output fptw_pkg::ram_cmd_type  ram_cmd,
   input  fptw_pkg::entry_type    ram_rdata
);

   fptw_pkg::walk_state_type state_ff, state_in;
   logic [1:0]               lvl_ff, lvl_in;
   logic [35:0]              vpn_ff, vpn_in;
   fptw_pkg::frame_type      frame_ff, frame_in;
   fptw_pkg::result_type     res_ff, res_in;

   logic                     req_accept;
   logic                     slot_ok;
   logic [40:0]              frame_diff;
   logic                     outside;
   logic [8:0]               idx;
   fptw_pkg::entry_type      entry;

   assign req_accept = req.valid && req.ready;
   assign slot_ok    = ({17'b0, req.entry_slot} < 32'(fptw_pkg::STORE_DEPTH));
   assign frame_diff = {1'b0, frame_ff} - {1'b0, store_base_frame};
   assign outside    = frame_diff[40] ||
                       (frame_diff[39:0] >= 40'(fptw_pkg::STORE_PAGES));
   assign entry      = ram_rdata;

   always_comb begin
      case (lvl_ff)
         2'd0: idx = vpn_ff[35:27];
         2'd1: idx = vpn_ff[26:18];
         2'd2: idx = vpn_ff[17:9];
         default: idx = vpn_ff[8:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fptw_pkg::WS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lvl_ff   <= lvl_in;
      vpn_ff   <= vpn_in;
      frame_ff <= frame_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      vpn_in        = vpn_ff;
      frame_in      = frame_ff;
      res_in        = res_ff;
      req.ready     = 1'b0;
      res_valid     = 1'b0;
      ram_cmd.we    = 1'b0;
      ram_cmd.waddr = fptw_pkg::store_addr_type'(req.entry_slot);
      ram_cmd.wdata = req.entry_value;
      ram_cmd.re    = 1'b0;
      ram_cmd.raddr = fptw_pkg::store_addr_type'({frame_diff[39:0], idx});

      unique case (state_ff)
         fptw_pkg::WS_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.cmd == fptw_pkg::CMD_WRITE) begin
                  ram_cmd.we         = slot_ok;
                  res_in.phys_addr   = '0;
                  res_in.status      = fptw_pkg::ST_WRITE_DONE;
                  res_in.fault_level = 2'd0;
                  state_in           = fptw_pkg::WS_DONE;
               end else begin
                  vpn_in   = req.virt_addr[47:12];
                  frame_in = root_frame;
                  lvl_in   = 2'd0;
                  state_in = fptw_pkg::WS_CHECK;
               end
            end
         end
         fptw_pkg::WS_CHECK: begin
            if (outside) begin
               res_in.phys_addr   = '0;
               res_in.status      = fptw_pkg::ST_OUTSIDE;
               res_in.fault_level = lvl_ff;
               state_in           = fptw_pkg::WS_DONE;
            end else begin
               ram_cmd.re = 1'b1;
               state_in   = fptw_pkg::WS_EVAL;
            end
         end
         fptw_pkg::WS_EVAL: begin
            res_in.fault_level = lvl_ff;
            state_in           = fptw_pkg::WS_DONE;
            if (!entry[0]) begin
               res_in.phys_addr = '0;
               res_in.status    = fptw_pkg::ST_NOT_PRESENT;
            end else if (lvl_ff == 2'd1 && entry[7]) begin
               res_in.phys_addr = {entry[51:30], vpn_ff[17:0], 12'b0};
               res_in.status    = fptw_pkg::ST_MAP_1G;
            end else if (lvl_ff == 2'd2 && entry[7]) begin
               res_in.phys_addr = {entry[51:21], vpn_ff[8:0], 12'b0};
               res_in.status    = fptw_pkg::ST_MAP_2M;
            end else if (lvl_ff == 2'd3) begin
               res_in.phys_addr = {entry[51:12], 12'b0};
               res_in.status    = fptw_pkg::ST_MAP_4K;
            end else begin
               frame_in = entry[51:12];
               lvl_in   = lvl_ff + 2'd1;
               state_in = fptw_pkg::WS_CHECK;
            end
         end
         fptw_pkg::WS_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = fptw_pkg::WS_IDLE;
            end
         end
         default: begin
            state_in = fptw_pkg::WS_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_cmd.we && ram_cmd.re))
      else $error("table RAM read and write in the same cycle");

   a_translate_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req.cmd == fptw_pkg::CMD_TRANSLATE) |=>
         (state_ff == fptw_pkg::WS_CHECK && lvl_ff == 2'd0))
      else $error("translation did not start at the top level");

   a_level_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fptw_pkg::WS_EVAL && state_in == fptw_pkg::WS_CHECK) |=>
         (lvl_ff == $past(lvl_ff) + 2'd1))
      else $error("walk level did not advance by one");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.re |=> state_ff == fptw_pkg::WS_EVAL)
      else $error("table read not followed by evaluation");

   a_fault_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.status == fptw_pkg::ST_NOT_PRESENT ||
                     res.status == fptw_pkg::ST_OUTSIDE ||
                     res.status == fptw_pkg::ST_WRITE_DONE)) |-> res.phys_addr == '0)
      else $error("nonzero address on fault or write transaction");

endmodule

@@ rtl/four_level_page_table_walker.sv @@
// A write goes from acceptance straight to the result state. A translation does, per table level,
// a range check that issues the read address and then an evaluation of the registered RAM read,
// and stops early at a table outside the store. The result is registered before it leaves.
// One transaction at a time: a new request is taken only once the last result is in the output register.
// Reset clears the walker state, the output valid flag and both CSRs; the table RAM is not
// cleared and its entries are undefined until written.
module four_level_page_table_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [39:0] csr_wdata,
   fptw_req_if.sink    req_chan,
   fptw_rsp_if.source  rsp_chan
);

   fptw_pkg::frame_type   root_frame_ff, root_frame_in;
   fptw_pkg::frame_type   store_base_ff, store_base_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fptw_pkg::result_type  rsp_res_ff, rsp_res_in;

   logic                  out_free;
   logic                  res_valid;
   fptw_pkg::result_type  res;
   fptw_pkg::ram_cmd_type ram_cmd;
   fptw_pkg::entry_type   ram_rdata;

   always_comb begin
      root_frame_in = root_frame_ff;
      store_base_in = store_base_ff;
      if (csr_we) begin
         unique case (fptw_pkg::csr_index_type'(csr_index))
            fptw_pkg::CSR_ROOT_FRAME: root_frame_in = csr_wdata;
            fptw_pkg::CSR_STORE_BASE: store_base_in = csr_wdata;
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_res_in   = (res_valid && out_free) ? res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
         store_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         root_frame_ff <= root_frame_in;
         store_base_ff <= store_base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.phys_addr   = rsp_res_ff.phys_addr;
   assign rsp_chan.status      = rsp_res_ff.status;
   assign rsp_chan.fault_level = rsp_res_ff.fault_level;

   fptw_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .root_frame       (root_frame_ff),
      .store_base_frame (store_base_ff),
      .out_free         (out_free),
      .res_valid        (res_valid),
      .res              (res),
      .ram_cmd          (ram_cmd),
      .ram_rdata        (ram_rdata)
   );

   fptw_ram #(
      .WIDTH (fptw_pkg::ENTRY_W),
      .DEPTH (fptw_pkg::STORE_DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

endmodule

@@ tb/sv/tb_four_level_page_table_walker.sv @@
`timescale 1ns / 1ps

module tb_four_level_page_table_walker;
   import fptw_pkg::*;

   localparam logic [39:0] FRAME_MAX = 40'hFF_FFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [39:0] csr_wdata;

   fptw_req_if req_chan ();
   fptw_rsp_if rsp_chan ();

   four_level_page_table_walker dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // walker mirror
   entry_type   table_mirror [STORE_DEPTH];
   bit          slot_loaded [STORE_DEPTH];
   frame_type   root_frame_q;
   frame_type   store_base_q;

   result_type  pending_results [$];
   logic [47:0] recent_vas [$];
   int unsigned error_count;
   bit          gaps_on;
   int unsigned ready_hold;

   always #6 clock = ~clock;

   initial begin
      #5_000_000;
      $display("four_level_page_table_walker verification failed");
      $finish;
   end

   function automatic result_type make_result(input logic [51:0] pa, input status_type st,
                                              input logic [1:0] lvl);
      result_type r;
      r.phys_addr   = pa;
      r.status      = st;
      r.fault_level = lvl;
      return r;
   endfunction

   // Returns 0 when the walk would touch a slot never loaded; that slot is reported.
   function automatic bit walk_translation(input logic [47:0] va, output result_type res,
                                           output int unsigned gap_slot,
                                           output logic [1:0] gap_level);
      logic [47:0] page_va;
      frame_type   frame;
      logic [39:0] offset;
      entry_type   pte;
      logic [8:0]  idx;
      int unsigned slot;
      int          lvl;
      page_va   = {va[47:12], 12'h000};
      frame     = root_frame_q;
      res       = make_result(52'd0, ST_NOT_PRESENT, 2'd3);
      gap_slot  = 0;
      gap_level = 2'd0;
      for (lvl = 0; lvl < 4; lvl++) begin
         offset = frame - store_base_q;
         if (frame < store_base_q || offset >= STORE_PAGES) begin
            res = make_result(52'd0, ST_OUTSIDE, 2'(lvl));
            return 1;
         end
         idx  = 9'(page_va >> (39 - 9 * lvl));
         slot = int'(offset[5:0]) * ENTRIES_PER_TABLE + int'(idx);
         if (!slot_loaded[slot]) begin
            gap_slot  = slot;
            gap_level = 2'(lvl);
            return 0;
         end
         pte = table_mirror[slot];
         if (!pte[0]) begin
            res = make_result(52'd0, ST_NOT_PRESENT, 2'(lvl));
            return 1;
         end
         if (lvl == 1 && pte[7]) begin
            res = make_result({pte[51:30], page_va[29:0]}, ST_MAP_1G, 2'd1);
            return 1;
         end
         if (lvl == 2 && pte[7]) begin
            res = make_result({pte[51:21], page_va[20:0]}, ST_MAP_2M, 2'd2);
            return 1;
         end
         if (lvl == 3) begin
            res = make_result({pte[51:12], 12'h000}, ST_MAP_4K, 2'd3);
            return 1;
         end
         frame = pte[51:12];
      end
      return 1;
   endfunction

   // Mostly present entries; pointers usually land on a page of the current window.
   function automatic entry_type fresh_entry(input logic [1:0] lvl);
      entry_type   pte;
      int unsigned pick;
      pte  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         pte[0] = 1'b0;
      end else begin
         pte[0] = 1'b1;
         if (lvl == 2'd3) begin
            // 4 KB leaf, bit 7 left random
         end else if (lvl != 2'd0 && pick < 35) begin
            pte[7] = 1'b1;
         end else begin
            if (lvl != 2'd0)
               pte[7] = 1'b0;
            if (pick < 10)
               pte[51:12] = 40'({$urandom, $urandom});
            else
               pte[51:12] = store_base_q + 40'($urandom_range(0, STORE_PAGES - 1));
         end
      end
      return pte;
   endfunction

   function automatic logic [47:0] pick_va();
      logic [47:0] va;
      logic [47:0] fresh;
      logic [47:0] mask;
      int unsigned k;
      fresh = 48'({$urandom, $urandom});
      if (recent_vas.size() == 0 || $urandom_range(0, 9) < 3) begin
         va = fresh;
      end else begin
         va   = recent_vas[$urandom_range(0, recent_vas.size() - 1)];
         k    = $urandom_range(1, 4);
         mask = {48{1'b1}} << (48 - 9 * k);
         va   = (va & mask) | (fresh & ~mask);
      end
      if (recent_vas.size() < 64)
         recent_vas.push_back(va);
      else
         recent_vas[$urandom_range(0, 63)] = va;
      return va;
   endfunction

   task automatic send_item(input cmd_type c, input logic [47:0] va,
                            input logic [14:0] slot, input entry_type value);
      result_type  res;
      int unsigned gs;
      logic [1:0]  gl;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= c;
      if (c == CMD_WRITE) begin
         req_chan.virt_addr   <= 48'({$urandom, $urandom});
         req_chan.entry_slot  <= slot;
         req_chan.entry_value <= value;
         table_mirror[slot] = value;
         slot_loaded[slot]  = 1'b1;
         res = make_result(52'd0, ST_WRITE_DONE, 2'd0);
      end else begin
         req_chan.virt_addr   <= va;
         req_chan.entry_slot  <= 15'($urandom);
         req_chan.entry_value <= {$urandom, $urandom};
         void'(walk_translation(va, res, gs, gl));
      end
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_results.push_back(res);
   endtask

   // Loads any missing table entry on the path first, then translates.
   task automatic translate_va(input logic [47:0] va);
      result_type  res;
      int unsigned gs;
      logic [1:0]  gl;
      while (!walk_translation(va, res, gs, gl))
         send_item(CMD_WRITE, 48'd0, 15'(gs), fresh_entry(gl));
      send_item(CMD_TRANSLATE, va, 15'd0, 64'd0);
   endtask

   task automatic write_entry(input int unsigned slot, input entry_type value);
      send_item(CMD_WRITE, 48'd0, 15'(slot), value);
   endtask

   task automatic settle_idle();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_csr(input csr_index_type idx, input frame_type value);
      settle_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ROOT_FRAME)
         root_frame_q = value;
      else
         store_base_q = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_traffic(input int unsigned n, input bit quiet_tail);
      int unsigned k;
      for (k = 0; k < n; k++) begin
         if (k % 64 == 0)
            gaps_on = !(quiet_tail && k >= n / 2) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 12)
            send_item(CMD_WRITE, 48'd0, 15'($urandom), {$urandom, $urandom});
         else
            translate_va(pick_va());
      end
   endtask

   task automatic test_directed_walks();
      set_csr(CSR_ROOT_FRAME, 40'd0);
      set_csr(CSR_STORE_BASE, 40'd0);
      gaps_on = 1'b1;
      // page 0 top level, page 1 level 1, page 2 level 2, page 3 last level
      write_entry(0,    64'h0000_0000_0000_1081);
      write_entry(1,    64'hFFFF_FFFF_FFFF_FFFF);
      write_entry(511,  64'h0000_0000_0000_0000);
      write_entry(512,  64'h0000_0000_0000_2001);
      write_entry(513,  64'hFFFF_FFFF_FFFF_FFFF);
      write_entry(514,  64'h0000_0000_0004_0001);
      write_entry(515,  64'h0000_0000_0000_0000);
      write_entry(1024, 64'h0000_0000_0000_3001);
      write_entry(1025, 64'hFFFF_FFFF_FFFF_FFFE);
      write_entry(1026, 64'h0000_0000_0006_4001);
      write_entry(1535, 64'hA5A5_5A5A_C3E0_0081);
      write_entry(1536, 64'hFFFF_FFFF_FFFF_FFFF);
      write_entry(1537, 64'h0000_0000_0000_0000);
      translate_va(48'h0000_0000_0000);
      translate_va(48'h0000_0000_1FFF);
      translate_va(48'h0000_0020_0000);
      translate_va(48'h0000_0040_0ABC);
      translate_va(48'h0000_3FFF_FFFF);
      translate_va(48'h0000_7FFF_FFFF);
      translate_va(48'h0000_8000_0000);
      translate_va(48'h0000_C000_0000);
      translate_va(48'hFFFF_FFFF_FFFF);
      translate_va(48'h0080_0000_0000);
   endtask

   task automatic test_root_outside_store();
      set_csr(CSR_ROOT_FRAME, FRAME_MAX);
      translate_va(48'h0000_0000_0000);
      translate_va(48'hFFFF_FFFF_FFFF);
      set_csr(CSR_STORE_BASE, FRAME_MAX);
      translate_va(48'h0000_0000_0000);
   endtask

   task automatic test_low_store_window();
      set_csr(CSR_STORE_BASE, 40'd0);
      set_csr(CSR_ROOT_FRAME, 40'd0);
      random_traffic(240, 1'b0);
   endtask

   task automatic test_top_store_window();
      set_csr(CSR_STORE_BASE, FRAME_MAX - 40'(STORE_PAGES - 1));
      set_csr(CSR_ROOT_FRAME, store_base_q + 40'd5);
      random_traffic(190, 1'b0);
   endtask

   task automatic test_last_frame_store();
      set_csr(CSR_STORE_BASE, FRAME_MAX);
      set_csr(CSR_ROOT_FRAME, FRAME_MAX);
      random_traffic(90, 1'b0);
   endtask

   task automatic test_mid_store_window();
      set_csr(CSR_STORE_BASE, 40'({$urandom, $urandom}) % (FRAME_MAX - 40'(STORE_PAGES)));
      set_csr(CSR_ROOT_FRAME, store_base_q + 40'($urandom_range(0, STORE_PAGES - 1)));
      random_traffic(300, 1'b1);
   endtask

   always @(posedge clock) begin
      if (ready_hold > 1) begin
         ready_hold <= ready_hold - 1;
      end else if (ready_hold == 1) begin
         ready_hold     <= 0;
         rsp_chan.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         ready_hold     <= $urandom_range(1, 3);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: status %0d phys_addr %h",
                   rsp_chan.status, rsp_chan.phys_addr);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.phys_addr !== want.phys_addr) begin
               $error("phys_addr: expected %h, got %h", want.phys_addr, rsp_chan.phys_addr);
               error_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.fault_level !== want.fault_level) begin
               $error("fault_level: expected %0d, got %0d",
                      want.fault_level, rsp_chan.fault_level);
               error_count++;
            end
         end
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_ROOT_FRAME;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.cmd         = CMD_TRANSLATE;
      req_chan.virt_addr   = '0;
      req_chan.entry_slot  = '0;
      req_chan.entry_value = '0;
      rsp_chan.ready       = 1'b0;
      root_frame_q         = '0;
      store_base_q         = '0;
      error_count          = 0;
      gaps_on              = 1'b0;
      ready_hold           = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_walks();
      test_root_outside_store();
      test_low_store_window();
      test_top_store_window();
      test_last_frame_store();
      test_mid_store_window();

      settle_idle();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("four_level_page_table_walker verification clean");
      end else begin
         $display("four_level_page_table_walker verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/fptw_pkg.sv
rtl/fptw_req_if.sv
rtl/fptw_rsp_if.sv
rtl/fptw_ram.sv
rtl/fptw_ctrl.sv
rtl/four_level_page_table_walker.sv
tb/sv/tb_four_level_page_table_walker.sv
